[sv/swseq_pkg.sv]
// shared types, codes and wave pattern function for the stepper wave sequencer
package swseq_pkg;

  // direction letters
  localparam logic [7:0] LETTER_CCW = 8'h4C;
  localparam logic [7:0] LETTER_CW  = 8'h52;

  // a raw digit is valid below this limit
  localparam logic [7:0] DIGIT_LIMIT = 8'd10;

  // last phase before a whole step completes
  localparam logic [1:0] PHASE_LAST = 2'd3;

  localparam int STEP_W = 10;

  // command status codes
  typedef enum logic [1:0] {
    STAT_TICK       = 2'd0,
    STAT_OK         = 2'd1,
    STAT_BAD_LETTER = 2'd2,
    STAT_BAD_DIGIT  = 2'd3
  } status_t;

  // one request: tick or four-byte command
  typedef struct packed {
    logic       action;
    logic [7:0] dir_letter;
    logic [7:0] digit_hundreds;
    logic [7:0] digit_tens;
    logic [7:0] digit_ones;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [3:0] coils;
    logic       stepped;
    logic       busy_res;
    logic [1:0] cmd_status;
  } res_t;

  // one-hot wave pattern for a direction and phase
  function automatic logic [3:0] wave_pattern(input logic cw, input logic [1:0] phase);
    logic [3:0] pat;
    if (cw) begin
      pat = 4'b0001 << phase;
    end else begin
      pat = 4'b1000 >> phase;
    end
    return pat;
  endfunction

endpackage

[sv/swseq_if.sv]
// request and result channel interfaces for the stepper wave sequencer
interface swseq_cmd_if;
  import swseq_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swseq_res_if;
  import swseq_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/stepper_command_wave_sequencer_top.sv]
// top level of the stepper wave sequencer: core plus result register and skid slot
//
//  channel  dir  payload                                              accepted when
//  cmd      in   action, dir_letter, digit_hundreds/tens/ones         cmd.valid && cmd.ready
//  res      out  coils, stepped, busy_res, cmd_status                 res.valid && res.ready
//
// one request per cycle while cmd.ready is high; its result is registered
// the state update and result are one pass of decode logic in the core
// rst (synchronous) clears state: counter-clockwise, phase 0, counts 0, coils off
// a stalled result moves into a skid slot so one more request is still taken;
// cmd.ready drops only while the skid slot is full
module stepper_command_wave_sequencer_top (
  input logic         clk,
  input logic         rst,
  swseq_cmd_if.sink   cmd,
  swseq_res_if.source res
);
  import swseq_pkg::*;

  logic accept;
  res_t result;
  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;

  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;

  // sequencer state and update
  swseq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (accept),
    .item    (cmd.data),
    .result  (result)
  );

  // result register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // payload moves, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

  // skid slot is only ever filled behind a held result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid slot full while result register empty");

  // a driven quarter step is a one-hot coil pattern from a tick
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stepped) |->
      ($onehot(out_data.coils) && out_data.cmd_status == STAT_TICK))
    else $error("stepped result without one-hot coils or not from a tick");

  // a request taken while the result stalls lands in the skid slot
  assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !res.ready) |=> skid_valid)
    else $error("request lost while result stalled");

endmodule

[sv/swseq_core.sv]
// sequencer state and the single-pass update for one request
module swseq_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  swseq_pkg::cmd_t  item,
  output swseq_pkg::res_t  result
);
  import swseq_pkg::*;

  logic              rotate_cw, rotate_cw_next;
  logic [1:0]        phase_index, phase_index_next;
  logic [STEP_W-1:0] target_steps, target_steps_next;
  logic [STEP_W-1:0] done_steps, done_steps_next;
  logic [3:0]        coil_drive, coil_drive_next;

  logic              h_ok, t_ok, o_ok;
  logic [STEP_W-1:0] h_val, t_val, o_val, digit_sum;
  logic              letter_ok;
  logic              stepped;
  status_t           status;

  // digit checks and weighted sum, stopping at the first bad digit
  assign h_ok  = item.digit_hundreds < DIGIT_LIMIT;
  assign t_ok  = item.digit_tens < DIGIT_LIMIT;
  assign o_ok  = item.digit_ones < DIGIT_LIMIT;
  assign h_val = STEP_W'(item.digit_hundreds[3:0]) * STEP_W'(100);
  assign t_val = STEP_W'(item.digit_tens[3:0]) * STEP_W'(10);
  assign o_val = STEP_W'(item.digit_ones[3:0]);

  always_comb begin
    digit_sum = '0;
    if (h_ok) begin
      digit_sum = h_val;
      if (t_ok) begin
        digit_sum = h_val + t_val;
        if (o_ok) begin
          digit_sum = h_val + t_val + o_val;
        end
      end
    end
  end

  assign letter_ok = (item.dir_letter == LETTER_CCW) || (item.dir_letter == LETTER_CW);

  // next state and status
  always_comb begin
    rotate_cw_next    = rotate_cw;
    phase_index_next  = phase_index;
    target_steps_next = target_steps;
    done_steps_next   = done_steps;
    coil_drive_next   = coil_drive;
    stepped           = 1'b0;
    status            = STAT_TICK;
    if (!item.action) begin
      if (done_steps < target_steps) begin
        coil_drive_next = wave_pattern(rotate_cw, phase_index);
        stepped         = 1'b1;
        if (phase_index == PHASE_LAST) begin
          phase_index_next = '0;
          done_steps_next  = done_steps + STEP_W'(1);
        end else begin
          phase_index_next = phase_index + 2'd1;
        end
      end
    end else if (letter_ok) begin
      rotate_cw_next    = item.dir_letter == LETTER_CW;
      done_steps_next   = '0;
      target_steps_next = digit_sum;
      status            = (h_ok && t_ok && o_ok) ? STAT_OK : STAT_BAD_DIGIT;
    end else begin
      status = STAT_BAD_LETTER;
    end
  end

  // result as seen after this request
  assign result.coils      = coil_drive_next;
  assign result.stepped    = stepped;
  assign result.busy_res   = done_steps_next < target_steps_next;
  assign result.cmd_status = status;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_cw    <= 1'b0;
      phase_index  <= '0;
      target_steps <= '0;
      done_steps   <= '0;
      coil_drive   <= '0;
    end else if (step_en) begin
      rotate_cw    <= rotate_cw_next;
      phase_index  <= phase_index_next;
      target_steps <= target_steps_next;
      done_steps   <= done_steps_next;
      coil_drive   <= coil_drive_next;
    end
  end

endmodule
